/* rtl/status_led_pattern_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// Status LED pattern sequencer assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_PATTERN_SEQUENCER_MACROS_SVH
`define STATUS_LED_PATTERN_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

`define SLPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SLPS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define SLPS_ASSERT(lbl, clk, rst_n, prop, msg)

`define SLPS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

/* rtl/slps_pkg.sv */
// ----------------------------------------------------------------------------
// Status LED pattern sequencer package
// Types, codes, colors and the SOS step table shared by the sequencer.
// ----------------------------------------------------------------------------
package slps_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned StepW     = 5;
  localparam int unsigned DurW      = 11;
  localparam int unsigned ChanW     = 8;

  localparam logic [IntervalW-1:0] IntervalReset = 16'd100;
  localparam logic [StepW-1:0]     SosLastStep   = 5'd17;

  localparam logic [1:0] OP_TICK       = 2'd0;
  localparam logic [1:0] OP_SET_MODE   = 2'd1;
  localparam logic [1:0] OP_SET_ABSENT = 2'd2;

  typedef enum logic [1:0] {
    MODE_PROVISIONING = 2'd0,
    MODE_CONNECTING   = 2'd1,
    MODE_DISCOVERING  = 2'd2,
    MODE_STREAMING    = 2'd3
  } mode_e;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } color_t;

  typedef struct packed {
    logic             sensor_absent;
    logic [1:0]       device_mode;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    mode_e            mode;
    logic             sensor_missing;
    logic [TimeW-1:0] last_update_ms;
    logic             pulse_phase;
    logic [StepW-1:0] sos_step;
    logic [TimeW-1:0] sos_last_ms;
  } state_t;

  localparam color_t ColorBlueFull   = '{red: 8'd0,  green: 8'd0,  blue: 8'd10};
  localparam color_t ColorBlueDim    = '{red: 8'd0,  green: 8'd0,  blue: 8'd2};
  localparam color_t ColorRed        = '{red: 8'd10, green: 8'd0,  blue: 8'd0};
  localparam color_t ColorYellowFull = '{red: 8'd10, green: 8'd10, blue: 8'd0};
  localparam color_t ColorYellowDim  = '{red: 8'd2,  green: 8'd2,  blue: 8'd0};
  localparam color_t ColorGreen      = '{red: 8'd0,  green: 8'd10, blue: 8'd0};
  localparam color_t ColorPurple     = '{red: 8'd15, green: 8'd0,  blue: 8'd20};
  localparam color_t ColorOff        = '{red: 8'd0,  green: 8'd0,  blue: 8'd0};

  function automatic logic [DurW-1:0] sos_duration(input logic [StepW-1:0] step);
    logic [DurW-1:0] dur;
    case (step) inside
      5'd5, 5'd6, 5'd8, 5'd10, 5'd11: dur = 11'd600;
      5'd17:                          dur = 11'd1400;
      default:                        dur = 11'd200;
    endcase
    return dur;
  endfunction

  function automatic color_t sos_color(input logic [StepW-1:0] step);
    return step[0] ? ColorOff : ColorPurple;
  endfunction

endpackage

/* rtl/slps_step.sv */
// ----------------------------------------------------------------------------
// Status LED pattern sequencer step logic
// Computes the next sequencer state and the optional color for one word.
// ----------------------------------------------------------------------------
module slps_step (
  input  logic [1:0]                     opcode_i,
  input  slps_pkg::item_t                item_i,
  input  slps_pkg::state_t               state_i,
  input  logic [slps_pkg::IntervalW-1:0] interval_i,
  output slps_pkg::state_t               state_o,
  output logic                           emit_o,
  output slps_pkg::color_t               color_o
);
  import slps_pkg::*;

  mode_e            mode;
  logic             do_tick;
  logic [StepW-1:0] sos_idx;
  logic [TimeW-1:0] sos_elapsed;
  logic [TimeW-1:0] mode_elapsed;
  logic             sos_due;
  logic             mode_due;

  assign mode    = (opcode_i == OP_SET_MODE) ? mode_e'(item_i.device_mode) : state_i.mode;
  assign do_tick = (opcode_i == OP_TICK) || (opcode_i == OP_SET_MODE);
  assign sos_idx = (state_i.sos_step <= SosLastStep) ? state_i.sos_step : '0;

  assign sos_elapsed  = item_i.now_ms - state_i.sos_last_ms;
  assign mode_elapsed = item_i.now_ms - state_i.last_update_ms;
  assign sos_due  = sos_elapsed >= {{(TimeW-DurW){1'b0}}, sos_duration(sos_idx)};
  assign mode_due = mode_elapsed >= {{(TimeW-IntervalW){1'b0}}, interval_i};

  always_comb begin
    state_o      = state_i;
    state_o.mode = mode;
    emit_o       = 1'b0;
    color_o      = ColorOff;
    unique case (opcode_i) inside
      OP_TICK, OP_SET_MODE: begin
        if (state_i.sensor_missing) begin
          if (sos_due) begin
            emit_o              = 1'b1;
            color_o             = sos_color(sos_idx);
            state_o.sos_last_ms = item_i.now_ms;
            state_o.sos_step    = (sos_idx == SosLastStep) ? '0 : sos_idx + 5'd1;
          end
        end else if (mode_due) begin
          emit_o                 = 1'b1;
          state_o.last_update_ms = item_i.now_ms;
          unique case (mode)
            MODE_PROVISIONING: begin
              state_o.pulse_phase = ~state_i.pulse_phase;
              color_o = state_i.pulse_phase ? ColorBlueDim : ColorBlueFull;
            end
            MODE_CONNECTING: color_o = ColorRed;
            MODE_DISCOVERING: begin
              state_o.pulse_phase = ~state_i.pulse_phase;
              color_o = state_i.pulse_phase ? ColorYellowDim : ColorYellowFull;
            end
            MODE_STREAMING: color_o = ColorGreen;
            default: color_o = ColorOff;
          endcase
        end
      end
      OP_SET_ABSENT: begin
        state_o.sensor_missing = item_i.sensor_absent;
        state_o.sos_step       = '0;
        state_o.sos_last_ms    = '0;
      end
      default: state_o = state_i;
    endcase
    if (!do_tick && opcode_i != OP_SET_ABSENT) begin
      state_o = state_i;
    end
  end

endmodule

/* rtl/status_led_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// Status LED pattern sequencer
// Turns timestamped event words into RGB colors for one status LED.
// ----------------------------------------------------------------------------
// The block takes one event word per clock while the input is not stalled, and
// answers it with at most one color word: the word is captured in an input
// register, evaluated combinationally against the sequencer state, and the
// color lands in an output register. A full output register that is not
// being taken holds the evaluation stage, and a held evaluation stage with a
// waiting word stalls the input.
`include "status_led_pattern_sequencer_macros.svh"

module status_led_pattern_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [slps_pkg::IntervalW-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // now_ms, device_mode, sensor_absent, pad
  input  logic [1:0]                     s_axis_tuser,  // opcode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata   // red, green, blue
);
  import slps_pkg::*;

  logic [IntervalW-1:0] interval_q;
  logic                 in_valid_q;
  logic [1:0]           opcode_q;
  item_t                item_q;
  state_t               state_q;
  state_t               state_d;
  logic                 out_valid_q;
  color_t               color_q;
  logic                 emit;
  color_t               color;
  logic                 fire;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      opcode_q <= s_axis_tuser;
      item_q   <= s_axis_tdata[$bits(item_t)-1:0];
    end
  end

  slps_step u_step (
    .opcode_i   (opcode_q),
    .item_i     (item_q),
    .state_i    (state_q),
    .interval_i (interval_q),
    .state_o    (state_d),
    .emit_o     (emit),
    .color_o    (color)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{mode: MODE_PROVISIONING, default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q     <= state_d;
        out_valid_q <= emit;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      color_q <= color;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = color_q;

  `SLPS_ASSERT(a_step_range, clk_i, rst_ni, state_q.sos_step <= SosLastStep,
               "SOS step out of range")
  `SLPS_ASSERT(a_stall_only_full, clk_i, rst_ni, !s_axis_tready |-> in_valid_q,
               "input stalled with empty input register")
  `SLPS_ASSERT_NEXT(a_absent_clears, clk_i, rst_ni, fire && opcode_q == OP_SET_ABSENT,
                    state_q.sos_step == '0 && state_q.sos_last_ms == '0,
                    "sensor absent write did not clear SOS timing")
  `SLPS_ASSERT_NEXT(a_idle_state, clk_i, rst_ni, !fire, state_q == $past(state_q),
                    "state changed without an evaluated word")

endmodule

/* sim/status_led_pattern_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// Status LED pattern sequencer testbench
// Drives timestamped event words into the sequencer and checks every color
// word it returns against a cycle-free model of the mode and SOS patterns.
// Directed tests cover the mode colors, time wrap, the SOS table and
// backpressure. Random traffic then runs under several tick intervals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module status_led_pattern_sequencer_tb;
  import slps_pkg::*;

  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int unsigned HoldCycles = 120;

  localparam color_t LedBlueHi   = '{red: 8'd0,  green: 8'd0,  blue: 8'd10};
  localparam color_t LedBlueLo   = '{red: 8'd0,  green: 8'd0,  blue: 8'd2};
  localparam color_t LedRed      = '{red: 8'd10, green: 8'd0,  blue: 8'd0};
  localparam color_t LedYellowHi = '{red: 8'd10, green: 8'd10, blue: 8'd0};
  localparam color_t LedYellowLo = '{red: 8'd2,  green: 8'd2,  blue: 8'd0};
  localparam color_t LedGreen    = '{red: 8'd0,  green: 8'd10, blue: 8'd0};
  localparam color_t LedPurple   = '{red: 8'd15, green: 8'd0,  blue: 8'd20};
  localparam color_t LedOff      = '{red: 8'd0,  green: 8'd0,  blue: 8'd0};

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  // Sequencer state as seen by the checker.
  logic [15:0] interval_ms   = 16'd100;
  mode_e       cur_mode      = MODE_PROVISIONING;
  logic        sensor_gone   = 1'b0;
  logic [31:0] mode_stamp_ms = '0;
  logic        phase_bit     = 1'b0;
  int unsigned sos_idx       = 0;
  logic [31:0] sos_stamp_ms  = '0;
  int unsigned sos_hold_ms [18] = '{200, 200, 200, 200, 200, 600, 600, 200, 600,
                                    200, 600, 600, 200, 200, 200, 200, 200, 1400};

  color_t pending_colors [$];
  int     failures      = 0;
  bit     src_idle      = 1'b1;
  bit     sink_idle     = 1'b1;
  bit     hold_off_req  = 1'b0;

  status_led_pattern_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic predict_led(input logic [1:0] op, input logic [31:0] now,
                             input logic [1:0] mode, input logic absent);
    color_t      col;
    bit          hit;
    int unsigned idx;
    hit = 1'b0;
    col = LedOff;
    case (op) inside
      OP_TICK, OP_SET_MODE: begin
        if (op == OP_SET_MODE) cur_mode = mode_e'(mode);
        if (sensor_gone) begin
          idx = (sos_idx < 18) ? sos_idx : 0;
          if (now - sos_stamp_ms >= sos_hold_ms[idx]) begin
            hit = 1'b1;
            sos_stamp_ms = now;
            // Even steps are lit, odd steps are dark.
            col = (idx % 2 == 0) ? LedPurple : LedOff;
            sos_idx = (idx == 17) ? 0 : idx + 1;
          end
        end else if (now - mode_stamp_ms >= {16'd0, interval_ms}) begin
          hit = 1'b1;
          mode_stamp_ms = now;
          case (cur_mode)
            MODE_PROVISIONING: begin
              phase_bit = ~phase_bit;
              col = phase_bit ? LedBlueHi : LedBlueLo;
            end
            MODE_CONNECTING: col = LedRed;
            MODE_DISCOVERING: begin
              phase_bit = ~phase_bit;
              col = phase_bit ? LedYellowHi : LedYellowLo;
            end
            default: col = LedGreen;
          endcase
        end
      end
      OP_SET_ABSENT: begin
        sensor_gone = absent;
        sos_idx = 0;
        sos_stamp_ms = '0;
      end
      default: ;
    endcase
    if (hit) pending_colors.push_back(col);
  endtask

  function automatic int unsigned source_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!src_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [31:0] now,
                           input logic [1:0] mode, input logic absent);
    int unsigned gap;
    gap = source_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, absent, mode, now};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_led(op, now, mode, absent);
    @(negedge clk_i);
  endtask

  task automatic send_tick(input logic [31:0] now);
    send_word(OP_TICK, now, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_mode(input mode_e mode, input logic [31:0] now);
    send_word(OP_SET_MODE, now, mode, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_absent(input logic absent, input logic [31:0] now);
    send_word(OP_SET_ABSENT, now, 2'($urandom_range(0, 3)), absent);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_interval(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    interval_ms = value;
  endtask

  // Aims the elapsed time at, just below, or past the threshold that applies, or picks a random time.
  function automatic logic [31:0] pick_time();
    int unsigned thr;
    int unsigned gap_ms;
    int unsigned r;
    logic [31:0] anchor;
    thr    = sensor_gone ? sos_hold_ms[(sos_idx < 18) ? sos_idx : 0] : interval_ms;
    anchor = sensor_gone ? sos_stamp_ms : mode_stamp_ms;
    r      = $urandom_range(0, 99);
    if (r < 15) gap_ms = thr;
    else if (r < 25) gap_ms = (thr == 0) ? 0 : thr - 1;
    else if (r < 70) gap_ms = $urandom_range(thr, thr + thr / 2 + 5);
    else if (r < 93) gap_ms = $urandom_range(0, thr);
    else return $urandom;
    return anchor + gap_ms;
  endfunction

  task automatic test_mode_colors();
    send_tick(32'd0);
    send_tick(32'd99);
    send_tick(32'd100);
    send_mode(MODE_CONNECTING, 32'd150);
    send_tick(32'd200);
    send_mode(MODE_DISCOVERING, 32'd300);
    send_mode(MODE_STREAMING, 32'd400);
    send_mode(MODE_PROVISIONING, 32'd500);
    send_word(OP_UNUSED, 32'd700, 2'd3, 1'b1);
    send_tick(32'd700);
  endtask

  task automatic test_time_wrap();
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h0000_0062);
    send_tick(32'h0000_0063);
  endtask

  task automatic test_sos_pattern();
    send_absent(1'b1, 32'h0000_1234);
    send_tick(32'd199);
    send_tick(32'd200);
    send_tick(32'd399);
    send_tick(32'd400);
    send_tick(32'd600);
    send_absent(1'b1, 32'd700);
    send_tick(32'd200);
    send_absent(1'b0, 32'd300);
    send_tick(32'h0000_1000);
  endtask

  task automatic test_backpressure();
    int i;
    wait_idle();
    write_interval(16'd0);
    src_idle = 1'b0;
    send_mode(MODE_STREAMING, $urandom);
    hold_off_req = 1'b1;
    for (i = 0; i < 24; i++) send_tick($urandom);
    wait_idle();
  endtask

  task automatic run_random_traffic();
    int unsigned spans [8];
    int          seg;
    int          i;
    int unsigned r;
    logic [1:0]  op;
    logic [1:0]  mode;
    logic        absent;
    spans = '{100, 65535, 0, 0, 1, 250, 600, 0};
    spans[3] = $urandom_range(0, 65535);
    spans[7] = $urandom_range(0, 1500);
    for (seg = 0; seg < 8; seg++) begin
      wait_idle();
      write_interval(16'(spans[seg]));
      src_idle  = ($urandom_range(0, 2) != 0);
      sink_idle = ($urandom_range(0, 2) != 0);
      for (i = 0; i < 45; i++) begin
        r      = $urandom_range(0, 99);
        mode   = 2'($urandom_range(0, 3));
        absent = 1'($urandom_range(0, 1));
        if (r < 72) begin
          op = OP_TICK;
        end else if (r < 86) begin
          op = OP_SET_MODE;
        end else if (r < 94) begin
          op = OP_SET_ABSENT;
          absent = ($urandom_range(0, 99) < 55);
        end else if (r < 97) begin
          op = OP_UNUSED;
        end else begin
          op = OP_TICK;
        end
        send_word(op, pick_time(), mode, absent);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_mode_colors();
    test_time_wrap();
    test_sos_pattern();
    test_backpressure();
    run_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (!sink_idle) begin
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 4) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  always @(posedge clk_i) begin : check_led
    color_t got;
    color_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_colors.size() == 0) begin
        $error("color word %h arrived with none expected", m_axis_tdata);
        failures++;
      end else begin
        want = pending_colors.pop_front();
        if (got.red != want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red);
          failures++;
        end
        if (got.green != want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green);
          failures++;
        end
        if (got.blue != want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue);
          failures++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
